// ===== rtl/core/mpq_pkg.sv =====
// Types, codes and compare function shared by the priority queue modules
package mpq_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_PEEK   = 2'd1;
    localparam logic [1:0] CMD_POP    = 2'd2;

    localparam logic [1:0] ST_VALID   = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] rec_tag;
        logic [15:0] rec_roll;
        logic [9:0]  rec_marks;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] top_tag;
        logic [15:0] top_roll;
        logic [9:0]  top_marks;
    } out_item_t;

    typedef struct packed {
        logic [9:0]  marks;
        logic [15:0] roll;
        logic [15:0] tag;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic pop;
    } cell_ctrl_t;

    // true when a strictly outranks b
    function automatic logic outranks(input entry_t a, input entry_t b);
        logic res;
        if (a.marks != b.marks)
        begin
            res = (a.marks > b.marks);
        end
        else
        begin
            res = (a.roll < b.roll);
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/mpq_cell.sv =====
// One sorted cell of the priority queue chain
module mpq_cell (
    input  logic               clk,
    input  mpq_pkg::cell_ctrl_t ctrl,
    input  logic               occ,
    input  mpq_pkg::entry_t    rec,
    input  mpq_pkg::entry_t    left_entry,
    input  logic               left_go,
    input  mpq_pkg::entry_t    right_entry,
    output mpq_pkg::entry_t    entry,
    output logic               go
);
    import mpq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // free cells always take the new record or a shifted one
    assign go = !occ || outranks(rec, entry_reg);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
        else if (ctrl.insert && go)
        begin
            entry_next = left_go ? left_entry : rec;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/core/max_priority_queue_compound_key.sv =====
// Top level: bounded max priority queue built from a chain of sorted cells
//
// Input channel in_valid/in_ready/in_item carries one command item: insert,
// peek or pop (code three acts as peek). Output channel out_valid/out_ready/
// out_item returns exactly one result item per command: the top record after
// the command, empty status with zero fields, or dropped status when an
// insert meets a full queue.
// All cells compare the new record with their own entry in parallel and
// shift one place, so the result is registered in the cycle after
// acceptance. Sustained rate is one item per cycle while the receiver
// takes results.
// The result register parts the channels: a new item is accepted whenever
// the register is empty or being emptied in the same cycle; while the
// receiver stalls, in_ready stays low and the queue holds still.
// Reset empties the queue (count to zero) and clears out_valid; cell
// contents are not cleared; entries at or above the count never reach out_item.
module max_priority_queue_compound_key #(
    parameter int DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mpq_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output mpq_pkg::out_item_t out_item
);
    import mpq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    out_item_t        out_item_reg;
    out_item_t        out_item_next;

    logic       accept;
    logic       is_full;
    cell_ctrl_t ctrl;
    entry_t     rec;
    entry_t     cell_q [DEPTH];
    logic [DEPTH-1:0] go;
    entry_t     new_top;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign is_full  = (count_reg == FULL);

    assign rec.marks = in_item.rec_marks;
    assign rec.roll  = in_item.rec_roll;
    assign rec.tag   = in_item.rec_tag;

    assign ctrl.insert = accept && (in_item.cmd == CMD_INSERT) && !is_full;
    assign ctrl.pop    = accept && (in_item.cmd == CMD_POP) && (count_reg != '0);

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            entry_t left_e;
            logic   left_g;
            entry_t right_e;
            if (i == 0)
            begin : g_first
                assign left_e = rec;
                assign left_g = 1'b0;
            end
            else
            begin : g_mid
                assign left_e = cell_q[i-1];
                assign left_g = go[i-1];
            end
            if (i == DEPTH - 1)
            begin : g_last
                assign right_e = cell_q[i];
            end
            else
            begin : g_inner
                assign right_e = cell_q[i+1];
            end
            mpq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occ         (CNT_W'(i) < count_reg),
                .rec         (rec),
                .left_entry  (left_e),
                .left_go     (left_g),
                .right_entry (right_e),
                .entry       (cell_q[i]),
                .go          (go[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        new_top    = cell_q[0];
        if (ctrl.insert)
        begin
            count_next = count_reg + CNT_W'(1);
            new_top    = go[0] ? rec : cell_q[0];
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - CNT_W'(1);
            new_top    = cell_q[1];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            if (count_next == '0)
            begin
                out_item_next = '{status: ST_EMPTY, top_tag: '0, top_roll: '0,
                                  top_marks: '0};
            end
            else
            begin
                out_item_next.status    = (in_item.cmd == CMD_INSERT && is_full) ?
                                          ST_DROPPED : ST_VALID;
                out_item_next.top_tag   = new_top.tag;
                out_item_next.top_roll  = new_top.roll;
                out_item_next.top_marks = new_top.marks;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("entry count beyond depth");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted item gave no result");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.status == ST_EMPTY) |->
        (out_item_reg.top_tag == '0 && out_item_reg.top_roll == '0 &&
         out_item_reg.top_marks == '0))
        else $error("empty result with non-zero fields");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.insert |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the queue");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_item.cmd == CMD_INSERT && is_full) |=>
        (out_item_reg.status == ST_DROPPED && count_reg == FULL))
        else $error("insert into full queue not dropped");

endmodule
